// File: hdl/gom_pkg.sv
// Shared types, constants and helpers for the gyro offset moving average block.
`timescale 1ns / 1ps

package gom_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int POS_W       = $clog2(WINDOW_MAX);
    localparam int LEN_W       = 7;
    localparam int AXES        = 3;
    localparam int RING_DEPTH  = AXES * WINDOW_MAX;
    localparam int RING_AW     = 2 + POS_W;
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
    localparam int RATE_W      = 32;
    localparam int WSUM_W      = 38;
    localparam int CSUM_W      = 48;
    localparam int DVD_W       = 48;
    localparam int DVS_W       = 16;
    localparam int DIV_CNT_W   = $clog2(DVD_W);
    localparam int MUL_CNT_W   = $clog2(GAIN_W);
    localparam int CFG_W       = 16;

    localparam logic signed [DVD_W-1:0] RATE_MAX = DVD_W'(64'sh7FFF_FFFF);
    localparam logic signed [DVD_W-1:0] RATE_MIN = -DVD_W'(64'sh8000_0000);

    typedef enum logic [1:0] {
        CFG_GAIN          = 2'd0,
        CFG_AVERAGE_ON    = 2'd1,
        CFG_WINDOW_LENGTH = 2'd2,
        CFG_CAL_SAMPLES   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_OFFSET = 2'd1,
        MODE_CAL    = 2'd2,
        MODE_SPARE  = 2'd3
    } mode_t;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MUL  = 10'b00_0000_0010,
        S_RD   = 10'b00_0000_0100,
        S_DIFF = 10'b00_0000_1000,
        S_ACC  = 10'b00_0001_0000,
        S_DIV  = 10'b00_0010_0000,
        S_NEXT = 10'b00_0100_0000,
        S_CAL  = 10'b00_1000_0000,
        S_CDIV = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } state_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [DVD_W-1:0] v);
        logic signed [RATE_W-1:0] r;
        if (v > RATE_MAX) begin
            r = RATE_W'(RATE_MAX);
        end else if (v < RATE_MIN) begin
            r = RATE_W'(RATE_MIN);
        end else begin
            r = v[RATE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/gyro_offset_moving_average.sv
// Top level: gyro rate scaling, offset removal, moving average and offset learning.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_sample_x/y/z, s_mode
//  m_       out        m_valid/m_ready    m_rate_x/y/z, m_cal_done
//  cfg_     in         cfg_wr_en          cfg_addr, cfg_wdata
//
// Axes run one after another through a bit-serial multiplier and, with averaging
// on, through a ring read/update and a 48-step serial divider. A calibration item
// adds a step that counts the sample, and the item that ends learning adds one
// division per axis to set the offsets.
// Reset clears sums, offsets, ring position and per-row ring valid bits at once.
// A new item is taken while a finished result still waits on m_ready.
`timescale 1ns / 1ps

module gyro_offset_moving_average import gom_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_x,
    input  logic signed [SAMPLE_W-1:0] s_sample_y,
    input  logic signed [SAMPLE_W-1:0] s_sample_z,
    input  logic [1:0]                 s_mode,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [RATE_W-1:0]   m_rate_x,
    output logic signed [RATE_W-1:0]   m_rate_y,
    output logic signed [RATE_W-1:0]   m_rate_z,
    output logic                       m_cal_done,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_addr,
    input  logic [CFG_W-1:0]           cfg_wdata
);

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]          gain_reg;
    logic                       avg_on_reg;
    logic [LEN_W-1:0]           win_len_reg;
    logic [15:0]                cal_samples_reg;

    logic signed [SAMPLE_W-1:0] samp_reg [AXES];
    mode_t                      mode_reg;
    logic [1:0]                 axis_reg;
    logic [1:0]                 axis_inc;
    logic [POS_W-1:0]           pos_reg;
    logic [WINDOW_MAX-1:0]      row_valid_reg;
    logic signed [WSUM_W-1:0]   wsum_reg [AXES];
    logic signed [CSUM_W-1:0]   csum_reg [AXES];
    logic [15:0]                cal_count_reg;
    logic signed [RATE_W-1:0]   offset_reg [AXES];
    logic signed [RATE_W-1:0]   val_reg;
    logic signed [RATE_W:0]     diff_reg;
    logic signed [RATE_W-1:0]   res_reg [AXES];
    logic                       done_flag_reg;

    logic                       m_valid_reg;
    logic signed [RATE_W-1:0]   m_rate_reg [AXES];
    logic                       m_cal_done_reg;

    logic [RATE_W-1:0]          ring_mem [0:RING_DEPTH-1];
    logic [RATE_W-1:0]          ring_rd_reg;
    logic [RING_AW-1:0]         ring_addr;
    logic                       ring_we;

    logic [LEN_W-1:0]           len;
    logic [15:0]                target;
    logic [16:0]                cnt_inc;
    logic [LEN_W-1:0]           pos_inc;
    logic                       accept;
    logic                       out_free;
    logic                       cfg_win;

    logic                       mul_start, mul_done;
    logic signed [SAMPLE_W-1:0] mul_a;
    logic signed [PROD_W-1:0]   mul_p;
    logic                       div_start, div_done;
    logic signed [DVD_W-1:0]    div_dvd;
    logic [DVS_W-1:0]           div_dvs;
    logic signed [DVD_W-1:0]    div_q;

    logic signed [RATE_W-1:0]   scaled;
    logic signed [RATE_W-1:0]   old_val;
    logic signed [WSUM_W-1:0]   wsum_new;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign cfg_win  = cfg_wr_en && (cfg_index_t'(cfg_addr) == CFG_WINDOW_LENGTH);
    assign axis_inc = axis_reg + 2'd1;

    // Window length zero counts as one, above the ring size as the ring size
    always_comb begin
        if (win_len_reg == '0) begin
            len = LEN_W'(1);
        end else if (win_len_reg > LEN_W'(WINDOW_MAX)) begin
            len = LEN_W'(WINDOW_MAX);
        end else begin
            len = win_len_reg;
        end
    end

    assign target  = (cal_samples_reg == '0) ? 16'd1 : cal_samples_reg;
    assign cnt_inc = {1'b0, cal_count_reg} + 17'd1;
    assign pos_inc = {1'b0, pos_reg} + LEN_W'(1);

    assign ring_addr = {axis_reg, pos_reg};
    assign ring_we   = (state_reg == S_DIFF);
    assign old_val   = row_valid_reg[pos_reg] ? $signed(ring_rd_reg) : '0;
    assign wsum_new  = wsum_reg[axis_reg] + WSUM_W'(diff_reg);

    // Scale, then remove the offset in offset mode
    always_comb begin
        logic signed [RATE_W-1:0] prod_sat;
        prod_sat = sat_rate(DVD_W'(mul_p));
        if (mode_reg == MODE_OFFSET) begin
            scaled = sat_rate(DVD_W'(prod_sat) - DVD_W'(offset_reg[axis_reg]));
        end else begin
            scaled = prod_sat;
        end
    end

    gom_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (gain_reg),
        .done    (mul_done),
        .product (mul_p)
    );

    gom_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = s_sample_x;
        div_start  = 1'b0;
        div_dvd    = DVD_W'(wsum_new);
        div_dvs    = DVS_W'(len);
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mul_start  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    state_next = avg_on_reg ? S_RD : S_NEXT;
                end
            end
            S_RD:   state_next = S_DIFF;
            S_DIFF: state_next = S_ACC;
            S_ACC: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                if (axis_reg == 2'd2) begin
                    state_next = (mode_reg == MODE_CAL) ? S_CAL : S_OUT;
                end else begin
                    mul_start  = 1'b1;
                    mul_a      = samp_reg[axis_inc];
                    state_next = S_MUL;
                end
            end
            S_CAL: begin
                if (cnt_inc >= {1'b0, target}) begin
                    div_start  = 1'b1;
                    div_dvd    = csum_reg[0];
                    div_dvs    = cnt_inc[15:0];
                    state_next = S_CDIV;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_CDIV: begin
                if (div_done) begin
                    if (axis_reg == 2'd2) begin
                        state_next = S_OUT;
                    end else begin
                        div_start = 1'b1;
                        div_dvd   = csum_reg[axis_inc];
                        div_dvs   = cal_count_reg;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_addr] <= val_reg;
        end
        ring_rd_reg <= ring_mem[ring_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            gain_reg        <= GAIN_W'(5121);
            avg_on_reg      <= 1'b1;
            win_len_reg     <= LEN_W'(8);
            cal_samples_reg <= 16'd100;
            pos_reg         <= '0;
            row_valid_reg   <= '0;
            cal_count_reg   <= '0;
            done_flag_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
            axis_reg        <= '0;
            for (int i = 0; i < AXES; i++) begin
                wsum_reg[i]   <= '0;
                csum_reg[i]   <= '0;
                offset_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_GAIN:          gain_reg        <= cfg_wdata[GAIN_W-1:0];
                    CFG_AVERAGE_ON:    avg_on_reg      <= cfg_wdata[0];
                    CFG_WINDOW_LENGTH: win_len_reg     <= cfg_wdata[LEN_W-1:0];
                    CFG_CAL_SAMPLES:   cal_samples_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            // A new window length empties the filter
            if (cfg_win) begin
                row_valid_reg <= '0;
                pos_reg       <= '0;
                for (int i = 0; i < AXES; i++) begin
                    wsum_reg[i] <= '0;
                end
            end

            if (m_valid_reg && m_ready && !(state_reg == S_OUT && out_free)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        axis_reg      <= '0;
                        done_flag_reg <= 1'b0;
                        if (avg_on_reg && ({1'b0, pos_reg} >= len)) begin
                            pos_reg <= '0;
                        end
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        val_reg <= scaled;
                    end
                end
                S_DIFF: begin
                    diff_reg <= (RATE_W+1)'(val_reg) - (RATE_W+1)'(old_val);
                    if (axis_reg == 2'd2) begin
                        row_valid_reg[pos_reg] <= 1'b1;
                    end
                end
                S_ACC: begin
                    wsum_reg[axis_reg] <= wsum_new;
                end
                S_DIV: begin
                    if (div_done) begin
                        val_reg <= div_q[RATE_W-1:0];
                    end
                end
                S_NEXT: begin
                    res_reg[axis_reg] <= val_reg;
                    if (mode_reg == MODE_CAL) begin
                        csum_reg[axis_reg] <= csum_reg[axis_reg] + CSUM_W'(val_reg);
                    end
                    if (axis_reg == 2'd2) begin
                        if (avg_on_reg) begin
                            pos_reg <= (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];
                        end
                    end else begin
                        axis_reg <= axis_inc;
                    end
                end
                S_CAL: begin
                    cal_count_reg <= cnt_inc[15:0];
                    axis_reg      <= '0;
                end
                S_CDIV: begin
                    if (div_done) begin
                        offset_reg[axis_reg] <= sat_rate(div_q);
                        if (axis_reg == 2'd2) begin
                            cal_count_reg <= '0;
                            done_flag_reg <= 1'b1;
                            for (int i = 0; i < AXES; i++) begin
                                csum_reg[i] <= '0;
                            end
                        end else begin
                            axis_reg <= axis_inc;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload capture needs no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            samp_reg[0] <= s_sample_x;
            samp_reg[1] <= s_sample_y;
            samp_reg[2] <= s_sample_z;
            mode_reg    <= (mode_t'(s_mode) == MODE_SPARE) ? MODE_PLAIN : mode_t'(s_mode);
        end
        if (state_reg == S_OUT && out_free) begin
            for (int i = 0; i < AXES; i++) begin
                m_rate_reg[i] <= res_reg[i];
            end
            m_cal_done_reg <= done_flag_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_rate_x   = m_rate_reg[0];
    assign m_rate_y   = m_rate_reg[1];
    assign m_rate_z   = m_rate_reg[2];
    assign m_cal_done = m_cal_done_reg;

    a_win_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_win |=> (row_valid_reg == '0 && pos_reg == '0))
        else $error("window length write left ring state behind");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second item taken before the first finished");

    a_cal_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg) && m_cal_done_reg) |-> cal_count_reg == '0)
        else $error("learning finished without clearing the count");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !out_free) |=> state_reg == S_OUT)
        else $error("result dropped while output stalled");

endmodule

// File: hdl/gom_mul.sv
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module gom_mul import gom_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [SAMPLE_W-1:0] mcand,
    input  logic        [GAIN_W-1:0]   mplier,
    output logic                      done,
    output logic signed [PROD_W-1:0]  product
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [MUL_CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [PROD_W-1:0]   acc_reg, acc_next;
    logic [GAIN_W-1:0]          mplier_reg, mplier_next;
    logic signed [SAMPLE_W-1:0] mcand_reg, mcand_next;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mplier_next = mplier;
            mcand_next  = mcand;
        end else if (busy_reg) begin
            // Horner form, most significant multiplier bit first
            acc_next = (acc_reg <<< 1)
                     + (mplier_reg[GAIN_W-1] ? PROD_W'(mcand_reg) : PROD_W'(0));
            mplier_next = mplier_reg << 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(GAIN_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg    <= acc_next;
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

endmodule

// File: hdl/gom_div.sv
// Restoring divider, signed dividend by unsigned divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module gom_div import gom_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DVD_W-1:0]  dividend,
    input  logic        [DVS_W-1:0]  divisor,
    output logic                     done,
    output logic signed [DVD_W-1:0]  quotient
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic [DVD_W-1:0]       dvd_reg, dvd_next;
    logic [DVS_W-1:0]       rem_reg, rem_next;
    logic [DVS_W-1:0]       dvs_reg, dvs_next;
    logic [DVS_W:0]         trial;
    logic [DVS_W:0]         trial_sub;

    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[DVD_W-1];
            dvd_next  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // quotient bits shift in where dividend bits leave
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial_sub[DVS_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_zero_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> divisor != '0)
        else $error("divider started with zero divisor");

endmodule
